@@ hdl/cvs_pkg.sv @@
// ----------------------------------------------------------------------------
// cvs_pkg: shared types and constants of the CAFF stream validator
// Event, error and parse phase codes, the result record, magic bytes.
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int DIM_BITS = 16;
	localparam int PROD_W   = 2 * DIM_BITS + 2;
	localparam int CMP_W    = (PROD_W > 64) ? PROD_W : 64;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_FIELD     = 4'd1,
		EV_CREATOR   = 4'd2,
		EV_CAPTION   = 4'd3,
		EV_TAG_CHAR  = 4'd4,
		EV_TAG_END   = 4'd5,
		EV_PIXEL     = 4'd6,
		EV_BLOCK_END = 4'd7,
		EV_FILE_OK   = 4'd8,
		EV_ERROR     = 4'd9
	} event_t;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_BAD_ID    = 4'd1,
		ERR_ORDER     = 4'd2,
		ERR_CAFF_MAG  = 4'd3,
		ERR_HDR_LEN   = 4'd4,
		ERR_EXTRA     = 4'd5,
		ERR_CIFF_MAG  = 4'd6,
		ERR_CSIZE     = 4'd7,
		ERR_MULTILINE = 4'd8,
		ERR_PIX_END   = 4'd9,
		ERR_TRUNC     = 4'd10,
		ERR_TOO_LARGE = 4'd11
	} err_t;

	typedef enum logic [3:0] {
		FID_NUM_ANIM = 4'd0,
		FID_YEAR     = 4'd1,
		FID_MONTH    = 4'd2,
		FID_DAY      = 4'd3,
		FID_HOUR     = 4'd4,
		FID_MINUTE   = 4'd5,
		FID_DURATION = 4'd6,
		FID_WIDTH    = 4'd7,
		FID_HEIGHT   = 4'd8
	} fid_t;

	typedef enum logic [4:0] {
		PH_ID, PH_LEN, PH_H_MAGIC, PH_H_SIZE, PH_H_NUM,
		PH_C_YEAR, PH_C_MON, PH_C_DAY, PH_C_HOUR, PH_C_MIN, PH_C_CLEN, PH_C_CREATOR,
		PH_A_DUR, PH_A_MAGIC, PH_A_HSIZE, PH_A_CSIZE, PH_A_W, PH_A_H,
		PH_A_CAP, PH_A_TAG, PH_A_PIX, PH_SKIP
	} phase_t;

	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_CREDITS = 2'd2;
	localparam logic [1:0] KIND_ANIM    = 2'd3;

	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef struct packed {
		event_t      ev;
		fid_t        fid;
		logic [63:0] fval;
		logic [7:0]  ch;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [63:0] frame;
		err_t        err;
		logic        done;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic ciff, input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = "C";
			2'd1: m = ciff ? "I" : "A";
			default: m = "F";
		endcase
		return m;
	endfunction

endpackage

@@ hdl/cvs_in_stage.sv @@
// ----------------------------------------------------------------------------
// cvs_in_stage: input register
// Holds one byte and its last flag until the parser takes it.
// ----------------------------------------------------------------------------
module cvs_in_stage import cvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

endmodule

@@ hdl/cvs_parser.sv @@
// ----------------------------------------------------------------------------
// cvs_parser: block and field parser
// Parse state and the per-byte step that produces one result.
// ----------------------------------------------------------------------------
module cvs_parser import cvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] din,
	input  logic       last,
	output res_t       res
);

	phase_t               phase_q, n_phase;
	logic [3:0]           cnt_q, n_cnt;
	logic [63:0]          acc_q, n_acc;
	logic [1:0]           kind_q, n_kind;
	logic [63:0]          len_q, n_len;
	logic [63:0]          rem_q, n_rem;
	logic [63:0]          bs_q, n_bs;
	logic [63:0]          anim_q, n_anim;
	logic [63:0]          sr_q, n_sr;
	logic [63:0]          cb_q, n_cb;
	logic [DIM_BITS-1:0]  w_q, n_w;
	logic [1:0]           pix_q, n_pix;
	logic [15:0]          rg_q, n_rg;
	err_t                 err_q, n_err;

	logic [63:0]          acc_new;
	logic [3:0]           cnt_inc;
	logic                 done8;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    trip;
	logic [1:0]           want;
	logic [63:0]          sr_dec;
	logic [63:0]          cb_dec;
	err_t                 e;
	res_t                 r;

	assign acc_new = acc_q | ({56'd0, din} << {cnt_q[2:0], 3'd0});
	assign cnt_inc = cnt_q + 4'd1;
	assign done8   = cnt_inc >= 4'd8;
	assign prod    = PROD_W'(w_q * acc_new[DIM_BITS-1:0]);
	assign trip    = {prod[PROD_W-2:0], 1'b0} + prod;
	assign sr_dec  = sr_q - 64'd1;
	assign cb_dec  = cb_q - 64'd1;
	assign want    = (bs_q == 64'd0) ? KIND_HEADER : (bs_q == 64'd1) ? KIND_CREDITS : KIND_ANIM;

	always_comb begin
		n_phase = phase_q; n_cnt = cnt_q; n_acc = acc_q; n_kind = kind_q;
		n_len = len_q; n_rem = rem_q; n_bs = bs_q; n_anim = anim_q;
		n_sr = sr_q; n_cb = cb_q; n_w = w_q; n_pix = pix_q; n_rg = rg_q;
		n_err = err_q;
		e = ERR_NONE;
		r = '0;

		if (err_q != ERR_NONE) begin
			r.ev = last ? EV_ERROR : EV_NONE;
		end else begin
			if (phase_q == PH_ID) begin
				if (bs_q >= 64'd2 && (bs_q - 64'd2) == anim_q) begin
					e = ERR_EXTRA;
				end else if (din < 8'd1 || din > 8'd3) begin
					e = ERR_BAD_ID;
				end else if (din[1:0] != want) begin
					e = ERR_ORDER;
				end else begin
					n_kind = din[1:0];
					n_bs = bs_q + 64'd1;
					n_cnt = '0;
					n_acc = '0;
					n_phase = PH_LEN;
				end
			end else if (phase_q == PH_LEN) begin
				n_acc = acc_new;
				n_cnt = cnt_inc;
				if (done8) begin
					n_acc = '0;
					n_cnt = '0;
					n_len = acc_new;
					n_rem = acc_new;
					if (acc_new == 64'd0) begin
						e = ERR_TRUNC;
					end else begin
						n_phase = (kind_q == KIND_HEADER) ? PH_H_MAGIC :
							(kind_q == KIND_CREDITS) ? PH_C_YEAR : PH_A_DUR;
					end
				end
			end else begin
				n_rem = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
				unique case (phase_q)
					PH_H_MAGIC, PH_A_MAGIC: begin
						if (din != magic_byte(phase_q == PH_A_MAGIC, cnt_q[1:0])) begin
							e = (phase_q == PH_H_MAGIC) ? ERR_CAFF_MAG : ERR_CIFF_MAG;
						end else begin
							n_cnt = cnt_inc;
							if (cnt_inc >= 4'd4) begin
								n_cnt = '0;
								n_phase = (phase_q == PH_H_MAGIC) ? PH_H_SIZE : PH_A_HSIZE;
							end
						end
					end
					PH_C_MON, PH_C_DAY, PH_C_HOUR, PH_C_MIN: begin
						r.ev = EV_FIELD;
						r.fval = {56'd0, din};
						unique case (phase_q)
							PH_C_MON: begin r.fid = FID_MONTH;  n_phase = PH_C_DAY;  end
							PH_C_DAY: begin r.fid = FID_DAY;    n_phase = PH_C_HOUR; end
							PH_C_HOUR: begin r.fid = FID_HOUR;  n_phase = PH_C_MIN;  end
							default: begin r.fid = FID_MINUTE;  n_phase = PH_C_CLEN; end
						endcase
					end
					PH_C_CREATOR: begin
						r.ev = EV_CREATOR;
						r.ch = din;
						n_sr = sr_dec;
						if (sr_dec == 64'd0) n_phase = PH_SKIP;
					end
					PH_A_CAP, PH_A_TAG: begin
						if (din == CH_NL && phase_q == PH_A_TAG) begin
							e = ERR_MULTILINE;
						end else if ((phase_q == PH_A_CAP && din == CH_NL) ||
								(phase_q == PH_A_TAG && din == CH_NUL)) begin
							if (phase_q == PH_A_TAG) r.ev = EV_TAG_END;
							if (n_rem > cb_q) begin
								n_phase = PH_A_TAG;
							end else if (n_rem == cb_q) begin
								if (cb_q == 64'd0) begin
									n_phase = PH_SKIP;
								end else begin
									n_phase = PH_A_PIX;
									n_pix = '0;
								end
							end else begin
								e = ERR_PIX_END;
							end
						end else begin
							r.ev = (phase_q == PH_A_CAP) ? EV_CAPTION : EV_TAG_CHAR;
							r.ch = din;
						end
					end
					PH_A_PIX: begin
						unique case (pix_q)
							2'd0: n_rg = {din, 8'd0};
							2'd1: n_rg = {rg_q[15:8], din};
							default: begin
								r.ev = EV_PIXEL;
								r.red = rg_q[15:8];
								r.green = rg_q[7:0];
								r.blue = din;
							end
						endcase
						n_pix = (pix_q >= 2'd2) ? 2'd0 : pix_q + 2'd1;
						n_cb = cb_dec;
						if (cb_dec == 64'd0) n_phase = PH_SKIP;
					end
					PH_H_SIZE, PH_H_NUM, PH_C_YEAR, PH_C_CLEN, PH_A_DUR, PH_A_HSIZE,
					PH_A_CSIZE, PH_A_W, PH_A_H: begin
						n_acc = acc_new;
						n_cnt = cnt_inc;
						if (phase_q == PH_C_YEAR ? (cnt_inc >= 4'd2) : done8) begin
							n_acc = '0;
							n_cnt = '0;
							unique case (phase_q)
								PH_H_SIZE: begin
									if (acc_new != len_q) e = ERR_HDR_LEN;
									else n_phase = PH_H_NUM;
								end
								PH_H_NUM: begin
									n_anim = acc_new;
									r.ev = EV_FIELD; r.fid = FID_NUM_ANIM; r.fval = acc_new;
									n_phase = PH_SKIP;
								end
								PH_C_YEAR: begin
									r.ev = EV_FIELD; r.fid = FID_YEAR; r.fval = acc_new;
									n_phase = PH_C_MON;
								end
								PH_C_CLEN: begin
									n_sr = acc_new;
									n_phase = (acc_new != 64'd0) ? PH_C_CREATOR : PH_SKIP;
								end
								PH_A_DUR: begin
									r.ev = EV_FIELD; r.fid = FID_DURATION; r.fval = acc_new;
									n_phase = PH_A_MAGIC;
								end
								PH_A_HSIZE: n_phase = PH_A_CSIZE;
								PH_A_CSIZE: begin
									n_cb = acc_new;
									n_phase = PH_A_W;
								end
								PH_A_W: begin
									if ((acc_new >> DIM_BITS) != 64'd0) begin
										e = ERR_TOO_LARGE;
									end else begin
										n_w = acc_new[DIM_BITS-1:0];
										r.ev = EV_FIELD; r.fid = FID_WIDTH; r.fval = acc_new;
										n_phase = PH_A_H;
									end
								end
								default: begin
									if ((acc_new >> DIM_BITS) != 64'd0) begin
										e = ERR_TOO_LARGE;
									end else if (CMP_W'(cb_q) != CMP_W'(trip)) begin
										e = ERR_CSIZE;
									end else begin
										r.ev = EV_FIELD; r.fid = FID_HEIGHT; r.fval = acc_new;
										n_phase = PH_A_CAP;
									end
								end
							endcase
						end
					end
					default: ;
				endcase
				if (e == ERR_NONE && n_rem == 64'd0) begin
					if (n_phase != PH_SKIP) begin
						e = ERR_TRUNC;
					end else begin
						n_phase = PH_ID;
						if (r.ev == EV_NONE) r.ev = EV_BLOCK_END;
					end
				end
			end

			if (e == ERR_NONE && last) begin
				if (n_phase == PH_ID && n_bs >= 64'd2) r.ev = EV_FILE_OK;
				else e = ERR_TRUNC;
			end
			if (e != ERR_NONE) begin
				r = '0;
				r.ev = EV_ERROR;
				n_err = e;
			end
		end

		r.frame = (n_bs >= 64'd2) ? n_bs - 64'd2 : 64'd0;
		r.err = n_err;
		r.done = last;

		if (last) begin
			n_phase = PH_ID; n_cnt = '0; n_acc = '0; n_kind = '0; n_len = '0;
			n_rem = '0; n_bs = '0; n_anim = '0; n_sr = '0; n_cb = '0; n_w = '0;
			n_pix = '0; n_rg = '0; n_err = ERR_NONE;
		end
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID; cnt_q <= '0; acc_q <= '0; kind_q <= '0; len_q <= '0;
			rem_q <= '0; bs_q <= '0; anim_q <= '0; sr_q <= '0; cb_q <= '0; w_q <= '0;
			pix_q <= '0; rg_q <= '0; err_q <= ERR_NONE;
		end else if (step) begin
			phase_q <= n_phase; cnt_q <= n_cnt; acc_q <= n_acc; kind_q <= n_kind;
			len_q <= n_len; rem_q <= n_rem; bs_q <= n_bs; anim_q <= n_anim;
			sr_q <= n_sr; cb_q <= n_cb; w_q <= n_w; pix_q <= n_pix; rg_q <= n_rg;
			err_q <= n_err;
		end
	end

endmodule

@@ hdl/cvs_out_stage.sv @@
// ----------------------------------------------------------------------------
// cvs_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cvs_out_stage import cvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	input  logic out_ready,
	output logic advance,
	output logic valid_s2,
	output res_t res_s2
);

	assign advance = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && advance) begin
			res_s2 <= res;
		end
	end

endmodule

@@ hdl/caff_container_stream_validator_top.sv @@
// ----------------------------------------------------------------------------
// caff_container_stream_validator_top: CAFF file stream checker
// Path: an accepted byte is held in the input reg, then parsed into the result
// reg, where it waits to be taken. Throughput: one byte per cycle while
// m_axis_tready takes results; the parse state updates once per byte.
// Reset: arst_n clears parse state and both stage valids; no clearing pass.
// After the last byte of a file the parser returns to its reset state.
// ----------------------------------------------------------------------------
module caff_container_stream_validator_top import cvs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] field_value, [71:64] char_value, [79:72] pixel_red,
	// [87:80] pixel_green, [95:88] pixel_blue, [159:96] frame_number,
	// [163:160] error_code, [167:164] zero
	output logic [167:0] m_axis_tdata,
	output logic [7:0]   m_axis_tuser,   // [3:0] event_res, [7:4] field_id
	output logic         m_axis_tlast    // file_done
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       step;
	res_t       res;
	res_t       res_s2;

	// a byte is parsed when it sits in the input reg and the result reg can load
	assign step = valid_s1 && advance;

	cvs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.take     (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	cvs_parser u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.din    (byte_s1),
		.last   (last_s1),
		.res    (res)
	);

	cvs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res       (res),
		.out_ready (m_axis_tready),
		.advance   (advance),
		.valid_s2  (m_axis_tvalid),
		.res_s2    (res_s2)
	);

	// pack result fields, lowest first; event and field id say what the data is
	assign m_axis_tdata = {4'd0, res_s2.err, res_s2.frame, res_s2.blue, res_s2.green,
		res_s2.red, res_s2.ch, res_s2.fval};
	assign m_axis_tuser = {res_s2.fid, res_s2.ev};
	assign m_axis_tlast = res_s2.done;

endmodule
